[hdl/pip_pkg.sv]
package pip_pkg;

  localparam int VC_W         = 5;
  localparam int HL_W         = 23;
  localparam int IDX_W        = 4;
  localparam int ORIENT_W     = 16;
  localparam int WIND_W       = 6;
  localparam int Q_FRAC       = 14;
  localparam int RND_HALF     = 1 << (Q_FRAC - 1);
  localparam int MIN_VERTICES = 3;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_HEIGHT_LIMIT = 1'b1;

  // quadrant step between consecutive vertices
  localparam logic signed [2:0] STEP_M3 = 3'sb101;
  localparam logic signed [2:0] STEP_P3 = 3'sb011;
  localparam logic signed [2:0] STEP_M2 = 3'sb110;
  localparam logic signed [2:0] STEP_P2 = 3'sb010;

  // sub-steps of the rotation and of the cross-product compare
  localparam logic [2:0] ROT_DXC = 3'd0;
  localparam logic [2:0] ROT_DYS = 3'd1;
  localparam logic [2:0] ROT_DYC = 3'd2;
  localparam logic [2:0] ROT_DXS = 3'd3;
  localparam logic [2:0] ROT_RY  = 3'd4;
  localparam logic [2:0] CR_PXCY = 3'd0;
  localparam logic [2:0] CR_PYCX = 3'd1;
  localparam logic [2:0] CR_CMP  = 3'd2;

  localparam logic [1:0] QUAD_TAB [2][2] = '{'{2'd0, 2'd1}, '{2'd3, 2'd2}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT,
    S_FIRST,
    S_WALK,
    S_CROSS,
    S_DONE
  } pip_state_e;

  typedef struct packed {
    logic [VC_W-1:0] vertex_count;
    logic [HL_W-1:0] height_limit;
  } pip_cfg_t;

  function automatic logic [1:0] quadrant(input logic xneg, input logic yneg);
    return QUAD_TAB[yneg][xneg];
  endfunction

endpackage

[hdl/pip_vtx_mem.sv]
module pip_vtx_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pip_mul.sv]
module pip_mul #(
  parameter int W = 28
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] prod_o
);

  logic signed [2*W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[hdl/pip_core.sv]
module pip_core import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pip_cfg_t                   cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic [IDX_W-1:0]           vertex_index_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_px_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_py_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  input  logic signed [ORIENT_W-1:0] orient_cos_i,
  input  logic signed [ORIENT_W-1:0] orient_sin_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       inside_res_o,
  output logic signed [WIND_W-1:0]   winding_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int RXW  = CW + 3;
  localparam int MW   = CW + 4;
  localparam int PW   = 2 * MW;
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int NCW  = (NW > VC_W) ? NW : VC_W;
  localparam int IXW  = ((IW > IDX_W) ? IW : IDX_W) + 1;
  localparam int HW   = (DW > HL_W + 1) ? DW : HL_W + 1;

  pip_state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  logic signed [DW-1:0]       dx_q, dy_q;
  logic signed [ORIENT_W-1:0] c_q, s_q;
  logic                       fail_q;
  logic [NW-1:0]              n_q, i_q;
  logic signed [PW-1:0]       acc_q;
  logic signed [RXW-1:0]      rx_q, ry_q;
  logic signed [MW-1:0]       px_q, py_q, cx_q, cy_q;
  logic [1:0]                 pq_q, cq_q;
  logic                       last_q, ccw_q;
  logic signed [WIND_W-1:0]   w_q;
  logic                       out_valid_q, inside_q;
  logic signed [WIND_W-1:0]   winding_q;

  logic                 in_acc, load_we, out_free, rd_en;
  logic [IW-1:0]        rd_addr, next_k;
  logic [NW-1:0]        nxt;
  logic [2*CW-1:0]      rd_data;
  logic signed [CW-1:0] vx, vy;
  logic signed [MW-1:0] cx_w, cy_w, mul_a, mul_b;
  logic signed [PW-1:0] prod, rot_sum;
  logic signed [RXW-1:0] rnd;
  logic [1:0]           q_w;
  logic signed [2:0]    d_w;
  logic                 cross_w, ge;
  logic signed [DW-1:0] dz;
  logic signed [HW-1:0] dz_ext, hl_ext;
  logic [NCW-1:0]       vc_ext, n_sel;
  logic [IXW-1:0]       idx_ext;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // load path
  assign idx_ext = IXW'(vertex_index_i);
  assign load_we = in_acc && (op_i == OP_LOAD) && (idx_ext < IXW'(MAX_VERTICES));

  // query setup
  assign dz     = DW'(point_z_i) - DW'(center_z_i);
  assign dz_ext = HW'(dz);
  assign hl_ext = HW'({1'b0, cfg_i.height_limit});
  assign vc_ext = NCW'(cfg_i.vertex_count);
  assign n_sel  = (vc_ext > NCW'(MAX_VERTICES)) ? NCW'(MAX_VERTICES) : vc_ext;

  pip_vtx_mem #(
    .DEPTH  (MAX_VERTICES),
    .DATA_W (2 * CW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (idx_ext[IW-1:0]),
    .wdata_i ({vertex_py_i, vertex_px_i}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  pip_mul #(
    .W (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // walk datapath
  assign vx      = rd_data[CW-1:0];
  assign vy      = rd_data[2*CW-1:CW];
  assign cx_w    = MW'(vx) - MW'(rx_q);
  assign cy_w    = MW'(vy) - MW'(ry_q);
  assign q_w     = quadrant(cx_w[MW-1], cy_w[MW-1]);
  assign d_w     = $signed({1'b0, q_w}) - $signed({1'b0, pq_q});
  assign cross_w = (d_w == STEP_M2) || (d_w == STEP_P2);
  assign ge      = acc_q >= prod;

  assign rot_sum = ((step_q == ROT_DYC) ? acc_q + prod : acc_q - prod) + PW'(RND_HALF);
  assign rnd     = rot_sum[Q_FRAC +: RXW];

  assign nxt    = i_q + NW'(1);
  assign next_k = (nxt == n_q) ? '0 : nxt[IW-1:0];

  always_comb begin
    mul_a = MW'(dx_q);
    mul_b = MW'(c_q);
    if (state_q == S_ROT) begin
      case (step_q)
        ROT_DYS: begin
          mul_a = MW'(dy_q);
          mul_b = MW'(s_q);
        end
        ROT_DYC: begin
          mul_a = MW'(dy_q);
          mul_b = MW'(c_q);
        end
        ROT_DXS: begin
          mul_a = MW'(dx_q);
          mul_b = MW'(s_q);
        end
        default: ;
      endcase
    end else if (state_q == S_CROSS) begin
      if (step_q == CR_PYCX) begin
        mul_a = py_q;
        mul_b = cx_q;
      end else begin
        mul_a = px_q;
        mul_b = cy_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (op_i == OP_QUERY)) begin
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        step_d = step_q + 3'd1;
        if (fail_q) begin
          state_d = S_DONE;
        end else if (step_q == ROT_RY) begin
          state_d = S_FIRST;
        end
      end
      S_FIRST: state_d = S_WALK;
      S_WALK: begin
        if (cross_w) begin
          state_d = S_CROSS;
        end else if (i_q == n_q) begin
          state_d = S_DONE;
        end
      end
      S_CROSS: begin
        step_d = step_q + 3'd1;
        if (step_q == CR_CMP) begin
          state_d = last_q ? S_DONE : S_WALK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = next_k;
    unique case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_ROT: begin
        rd_en   = (step_q == ROT_RY);
        rd_addr = '0;
      end
      S_FIRST: rd_en = 1'b1;
      S_WALK:  rd_en = (i_q != n_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (op_i == OP_QUERY)) begin
      dx_q   <= DW'(point_x_i) - DW'(center_x_i);
      dy_q   <= DW'(point_y_i) - DW'(center_y_i);
      c_q    <= orient_cos_i;
      s_q    <= orient_sin_i;
      n_q    <= n_sel[NW-1:0];
      fail_q <= (n_sel < NCW'(MIN_VERTICES)) ||
                ((cfg_i.height_limit != '0) && (dz_ext > hl_ext));
      w_q    <= '0;
      i_q    <= '0;
    end
    unique case (state_q)
      S_ROT: begin
        case (step_q)
          ROT_DYS: acc_q <= prod;
          ROT_DYC: rx_q  <= rnd;
          ROT_DXS: acc_q <= prod;
          ROT_RY:  ry_q  <= rnd;
          default: ;
        endcase
      end
      S_FIRST: begin
        px_q <= cx_w;
        py_q <= cy_w;
        pq_q <= q_w;
        i_q  <= NW'(1);
      end
      S_WALK: begin
        i_q    <= nxt;
        cx_q   <= cx_w;
        cy_q   <= cy_w;
        cq_q   <= q_w;
        last_q <= (i_q == n_q);
        ccw_q  <= (d_w == STEP_M2);
        if (d_w == STEP_M3) begin
          w_q <= w_q + WIND_W'(1);
        end else if (d_w == STEP_P3) begin
          w_q <= w_q - WIND_W'(1);
        end
        if (!cross_w) begin
          px_q <= cx_w;
          py_q <= cy_w;
          pq_q <= q_w;
        end
      end
      S_CROSS: begin
        if (step_q == CR_PYCX) begin
          acc_q <= prod;
        end
        if (step_q == CR_CMP) begin
          if (ccw_q && ge) begin
            w_q <= w_q + WIND_W'(1);
          end else if (!ccw_q && !ge) begin
            w_q <= w_q - WIND_W'(1);
          end
          px_q <= cx_q;
          py_q <= cy_q;
          pq_q <= cq_q;
        end
      end
      S_DONE: begin
        if (out_free) begin
          inside_q  <= (w_q != '0);
          winding_q <= w_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign winding_o    = winding_q;

endmodule

[hdl/point_in_polygon_winding.sv]
// Winding-number point-in-polygon test. Load transfers (op 0) write one
// vertex into the table and return no result. A query transfer (op 1)
// returns one result and walks n vertices, where n is vertex_count
// clamped to MAX_VERTICES; a query that fails the vertex-count or height
// check skips the rotation and the walk and returns a winding of 0. One
// shared signed multiplier does the four rotation products and both cross
// products of each two-quadrant edge, and the dual-port vertex table
// supplies one vertex per cycle outside the cross-product steps. in_stall_o
// is high from a query transfer until the output register holds its result.
// Query only vertex slots that have been loaded since reset.
module point_in_polygon_winding import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [IDX_W-1:0]              vertex_index_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_px_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_py_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  input  logic signed [ORIENT_W-1:0]    orient_cos_i,
  input  logic signed [ORIENT_W-1:0]    orient_sin_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic signed [WIND_W-1:0]      winding_o
);

  pip_cfg_t cfg_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_VERTEX_COUNT: cfg_q.vertex_count <= pwdata[VC_W-1:0];
        REG_HEIGHT_LIMIT: cfg_q.height_limit <= pwdata[HL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VERTEX_COUNT: prdata = APB_DW'(cfg_q.vertex_count);
      REG_HEIGHT_LIMIT: prdata = APB_DW'(cfg_q.height_limit);
      default:          prdata = '0;
    endcase
  end

  pip_core #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .vertex_index_i (vertex_index_i),
    .vertex_px_i    (vertex_px_i),
    .vertex_py_i    (vertex_py_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .center_z_i     (center_z_i),
    .orient_cos_i   (orient_cos_i),
    .orient_sin_i   (orient_sin_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o),
    .winding_o      (winding_o)
  );

endmodule

[hdl/pip_checker.sv]
module pip_checker import pip_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     op_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     inside_res_o,
  input logic signed [WIND_W-1:0] winding_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(inside_res_o) && $stable(winding_o))
    else $error("stalled result changed");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load transfer produced a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_QUERY) |=> in_stall_o)
    else $error("input taken while a query is in flight");

  a_inside_winding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inside_res_o == (winding_o != '0)))
    else $error("inside flag disagrees with winding count");

endmodule

bind point_in_polygon_winding pip_checker u_pip_checker (.*);
